>>> sv/mcs_pkg.sv
// Package for the motor command selector: payload words, codes and constants.
`timescale 1ns / 1ps

package mcs_pkg;

  localparam int CUR_LIMIT       = 400000;
  localparam int STANDSTILL_ERPM = 50;
  localparam int PARK_DUTY_ERPM  = 2000;
  localparam int BRAKE_HOLD_MS   = 1000;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 19;

  typedef enum logic [1:0] {
    CMD_NONE        = 2'd0,
    CMD_SET_CURRENT = 2'd1,
    CMD_ZERO_DUTY   = 2'd2,
    CMD_BRAKE       = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    RUN_DISABLED = 2'd0,
    RUN_RUNNING  = 2'd1,
    RUN_OTHER    = 2'd2,
    RUN_OTHER_HI = 2'd3
  } run_t;

  typedef enum logic [1:0] {
    PARK_NEVER  = 2'd0,
    PARK_IDLE   = 2'd1,
    PARK_ALWAYS = 2'd2,
    PARK_HOLD   = 2'd3
  } park_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BRAKE_CURRENT = 2'd0,
    REG_CLICK_CURRENT = 2'd1,
    REG_PARKING_MODE  = 2'd2,
    REG_MOVING_THRESH = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]         run_state;
    logic [17:0]        erpm_mag;
    logic [31:0]        time_ms;
    logic               request_valid;
    logic signed [19:0] request_ma;
    logic [7:0]         click_load;
  } in_word_t;

  typedef struct packed {
    cmd_t               command;
    logic signed [19:0] value_ma;
    logic               off_delay_50ms;
    logic               watchdog_kick;
  } out_word_t;

  typedef struct packed {
    logic [18:0] brake_current_ma;
    logic [16:0] click_current_ma;
    logic [1:0]  parking_mode;
    logic [17:0] moving_threshold_erpm;
  } cfg_t;

  typedef struct packed {
    logic               disabled_seen;
    logic               parking_active;
    logic [7:0]         click_remaining;
    logic               pending_request;
    logic signed [19:0] pending_current;
    logic [31:0]        brake_deadline_ms;
  } state_t;

endpackage

>>> sv/motor_command_selector.sv
// Top level of the motor command selector: input register, state, result register.
//
//   channel  ports                          direction  word
//   input    in_valid/in_stall/in_data      in         mcs_pkg::in_word_t
//   result   out_valid/out_stall/out_data   out        mcs_pkg::out_word_t
//   config   cfg_we/cfg_index/cfg_data      in         19-bit register data
//
// One word per cycle while the result side does not stall; an accepted word is held
// in the input register, then its result in the result register until taken.
// The tick state is read and updated in the single logic pass between the input
// register and the result register, so consecutive words chain without bubbles.
// Synchronous active-low reset clears state and both valid flags and resets config.
// A stall on the result side holds the result register, then backs up into in_stall.
`timescale 1ns / 1ps

module motor_command_selector (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  mcs_pkg::in_word_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output mcs_pkg::out_word_t             out_data,
  input  logic                           cfg_we,
  input  logic [mcs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mcs_pkg::CFG_DATA_W-1:0] cfg_data
);

  mcs_pkg::cfg_t      cfg;
  mcs_pkg::in_word_t  s1_data_r;
  logic               s1_valid_r, s1_valid_nxt;
  mcs_pkg::out_word_t out_data_r;
  logic               out_valid_r, out_valid_nxt;
  mcs_pkg::state_t    state_r, state_nxt;
  mcs_pkg::out_word_t step_result;
  logic               out_free;
  logic               s1_adv;
  logic               in_acc;

  mcs_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  mcs_step u_step (
    .item      (s1_data_r),
    .cfg       (cfg),
    .state     (state_r),
    .result    (step_result),
    .state_nxt (state_nxt)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign s1_adv   = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) s1_valid_nxt = 1'b1;
    else if (s1_adv) s1_valid_nxt = 1'b0;
    out_valid_nxt = s1_adv || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      // advance tick state only when the word moves to the result register
      if (s1_adv) state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) s1_data_r <= in_data;
    if (s1_adv) out_data_r <= step_result;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_delay_only_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.off_delay_50ms |-> out_data.command == mcs_pkg::CMD_SET_CURRENT)
    else $error("off delay on a command other than set current");

  a_no_kick_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.watchdog_kick |-> out_data.value_ma == 20'sd0)
    else $error("nonzero current on a disabled tick");

  a_value_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.value_ma <= 20'(mcs_pkg::CUR_LIMIT)) &&
                  (out_data.value_ma >= -20'(mcs_pkg::CUR_LIMIT)))
    else $error("result current outside saturation limits");

  a_zero_cmds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.command == mcs_pkg::CMD_NONE ||
                  out_data.command == mcs_pkg::CMD_ZERO_DUTY)
    |-> out_data.value_ma == 20'sd0)
    else $error("current carried on a no-action or zero-duty command");

  a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> s1_valid_r)
    else $error("accepted word lost from input register");

endmodule

>>> sv/mcs_cfg.sv
// Configuration register bank of the motor command selector.
`timescale 1ns / 1ps

module mcs_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [mcs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mcs_pkg::CFG_DATA_W-1:0]    cfg_data,
  output mcs_pkg::cfg_t                     cfg
);

  mcs_pkg::cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (mcs_pkg::reg_idx_t'(cfg_index))
        mcs_pkg::REG_BRAKE_CURRENT: cfg_nxt.brake_current_ma = cfg_data[18:0];
        mcs_pkg::REG_CLICK_CURRENT: cfg_nxt.click_current_ma = cfg_data[16:0];
        mcs_pkg::REG_PARKING_MODE:  cfg_nxt.parking_mode = cfg_data[1:0];
        mcs_pkg::REG_MOVING_THRESH: cfg_nxt.moving_threshold_erpm = cfg_data[17:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.brake_current_ma      <= '0;
      cfg_r.click_current_ma      <= '0;
      cfg_r.parking_mode          <= '0;
      cfg_r.moving_threshold_erpm <= 18'd1000;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> sv/mcs_step.sv
// Per-tick decision logic: result word and next state from one input word.
`timescale 1ns / 1ps

module mcs_step (
  input  mcs_pkg::in_word_t  item,
  input  mcs_pkg::cfg_t      cfg,
  input  mcs_pkg::state_t    state,
  output mcs_pkg::out_word_t result,
  output mcs_pkg::state_t    state_nxt
);

  localparam logic signed [20:0] LIM  = 21'(mcs_pkg::CUR_LIMIT);
  localparam logic signed [20:0] NLIM = -21'(mcs_pkg::CUR_LIMIT);

  function automatic logic signed [19:0] clamp21(input logic signed [20:0] v);
    logic signed [19:0] r;
    if (v > LIM) r = LIM[19:0];
    else if (v < NLIM) r = NLIM[19:0];
    else r = v[19:0];
    return r;
  endfunction

  logic               pr1;
  logic signed [19:0] pc1;
  logic [7:0]         click1;
  logic [7:0]         click2;
  logic signed [20:0] click_sum;
  logic signed [20:0] click_amp;
  logic signed [19:0] pc2;
  logic               pr2;
  logic [32:0]        dl_sum;
  logic [31:0]        dl_new;
  logic [31:0]        dl2;
  logic signed [19:0] brake_val;
  logic               park_set;
  logic               park_clr;

  always_comb begin
    // latch request and click load before anything else
    pr1    = state.pending_request | item.request_valid;
    pc1    = item.request_valid ? clamp21({item.request_ma[19], item.request_ma})
                                : state.pending_current;
    click1 = (item.click_load != 8'd0) ? item.click_load : state.click_remaining;

    click2    = click1 - 8'd1;
    click_amp = $signed({4'b0000, cfg.click_current_ma});
    click_sum = click2[0] ? ({pc1[19], pc1} + click_amp) : ({pc1[19], pc1} - click_amp);
    pc2       = (click1 != 8'd0) ? clamp21(click_sum) : pc1;
    pr2       = pr1 | (click1 != 8'd0);

    dl_sum = {1'b0, item.time_ms} + 33'(mcs_pkg::BRAKE_HOLD_MS);
    dl_new = dl_sum[32] ? 32'hFFFF_FFFF : dl_sum[31:0];
    dl2    = (item.erpm_mag > cfg.moving_threshold_erpm) ? dl_new : state.brake_deadline_ms;

    brake_val = (cfg.brake_current_ma > 19'(mcs_pkg::CUR_LIMIT))
                  ? LIM[19:0] : {1'b0, cfg.brake_current_ma};

    park_set = (cfg.parking_mode == mcs_pkg::PARK_ALWAYS) ||
               ((cfg.parking_mode == mcs_pkg::PARK_IDLE) &&
                (item.run_state != mcs_pkg::RUN_RUNNING) &&
                (item.erpm_mag < 18'(mcs_pkg::STANDSTILL_ERPM)));
    park_clr = (cfg.parking_mode == mcs_pkg::PARK_NEVER) ||
               (item.run_state == mcs_pkg::RUN_RUNNING);

    state_nxt = state;
    result.command        = mcs_pkg::CMD_NONE;
    result.value_ma       = '0;
    result.off_delay_50ms = 1'b0;
    result.watchdog_kick  = 1'b0;

    if (item.run_state == mcs_pkg::RUN_DISABLED) begin
      // keep latched request and clicks for later
      state_nxt.pending_request = pr1;
      state_nxt.pending_current = pc1;
      state_nxt.click_remaining = click1;
      state_nxt.disabled_seen   = 1'b1;
      if (!state.disabled_seen) result.command = mcs_pkg::CMD_SET_CURRENT;
    end else begin
      state_nxt.disabled_seen = 1'b0;
      if (park_set) state_nxt.parking_active = 1'b1;
      else if (park_clr) state_nxt.parking_active = 1'b0;
      state_nxt.click_remaining = (click1 != 8'd0) ? click2 : click1;
      result.watchdog_kick = 1'b1;
      state_nxt.pending_request = 1'b0;
      state_nxt.pending_current = '0;
      if (pr2) begin
        result.command        = mcs_pkg::CMD_SET_CURRENT;
        result.value_ma       = pc2;
        result.off_delay_50ms = 1'b1;
      end else begin
        state_nxt.brake_deadline_ms = dl2;
        if (item.time_ms > dl2) begin
          // release: pending state stays as it was
          result.command = mcs_pkg::CMD_SET_CURRENT;
          state_nxt.pending_request = pr2;
          state_nxt.pending_current = pc2;
        end else if (state_nxt.parking_active &&
                     (item.erpm_mag < 18'(mcs_pkg::PARK_DUTY_ERPM))) begin
          result.command = mcs_pkg::CMD_ZERO_DUTY;
        end else begin
          result.command  = mcs_pkg::CMD_BRAKE;
          result.value_ma = brake_val;
        end
      end
    end
  end

endmodule

>>> tb/tb.sv
// Self-checking testbench for motor_command_selector, with its own per-tick command predictor.
`timescale 1ns / 1ps

module tb;
  import mcs_pkg::*;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_word_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_word_t             out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  motor_command_selector u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Register copies
  logic [18:0] brake_ma;
  logic [16:0] click_ma;
  park_t       park_mode;
  logic [17:0] moving_thresh;

  // Tick state copies
  logic        dis_seen;
  logic        park_on;
  logic [7:0]  clicks_left;
  logic        pend_req;
  int          pend_ma;
  logic [31:0] brake_deadline;

  out_word_t   expected_cmds[$];
  int          mismatches;
  logic        idle_on;
  int          hold_len;
  logic [31:0] now_ms;

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic int clamp_ma(longint v);
    if (v > CUR_LIMIT) return CUR_LIMIT;
    if (v < -CUR_LIMIT) return -CUR_LIMIT;
    return int'(v);
  endfunction

  function automatic out_word_t make_cmd(cmd_t c, int v, logic d, logic k);
    out_word_t r;
    r.command        = c;
    r.value_ma       = 20'(v);
    r.off_delay_50ms = d;
    r.watchdog_kick  = k;
    return r;
  endfunction

  // Advance the tick state by one word and return the command it selects.
  function automatic out_word_t select_command(in_word_t w);
    logic [31:0] hold_limit;
    out_word_t   r;
    hold_limit = 32'hFFFF_FFFF - 32'(BRAKE_HOLD_MS);
    if (w.request_valid) begin
      pend_req = 1'b1;
      pend_ma  = clamp_ma(longint'($signed(w.request_ma)));
    end
    if (w.click_load != 8'd0) clicks_left = w.click_load;

    if (w.run_state == RUN_DISABLED) begin
      if (!dis_seen) begin
        dis_seen = 1'b1;
        return make_cmd(CMD_SET_CURRENT, 0, 1'b0, 1'b0);
      end
      return make_cmd(CMD_NONE, 0, 1'b0, 1'b0);
    end
    dis_seen = 1'b0;

    if (park_mode == PARK_ALWAYS || (park_mode == PARK_IDLE &&
        w.run_state != RUN_RUNNING && w.erpm_mag < STANDSTILL_ERPM)) begin
      park_on = 1'b1;
    end else if (park_mode == PARK_NEVER || w.run_state == RUN_RUNNING) begin
      park_on = 1'b0;
    end

    if (clicks_left != 8'd0) begin
      pend_req    = 1'b1;
      clicks_left = clicks_left - 8'd1;
      if (!clicks_left[0]) pend_ma = clamp_ma(longint'(pend_ma) - longint'(click_ma));
      else                 pend_ma = clamp_ma(longint'(pend_ma) + longint'(click_ma));
    end

    if (pend_req) begin
      r = make_cmd(CMD_SET_CURRENT, pend_ma, 1'b1, 1'b1);
    end else begin
      if (w.erpm_mag > moving_thresh) begin
        brake_deadline = (w.time_ms > hold_limit) ? 32'hFFFF_FFFF :
                         w.time_ms + 32'(BRAKE_HOLD_MS);
      end
      // release leaves the pending state untouched
      if (w.time_ms > brake_deadline) return make_cmd(CMD_SET_CURRENT, 0, 1'b0, 1'b1);
      if (park_on && w.erpm_mag < PARK_DUTY_ERPM)
        r = make_cmd(CMD_ZERO_DUTY, 0, 1'b0, 1'b1);
      else
        r = make_cmd(CMD_BRAKE, clamp_ma(longint'(brake_ma)), 1'b0, 1'b1);
    end
    pend_req = 1'b0;
    pend_ma  = 0;
    return r;
  endfunction

  // Check results first, then queue the prediction for a word accepted on the same edge.
  always @(posedge clk) begin
    out_word_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_cmds.size() == 0) begin
        $error("unexpected result word: command %0d value_ma %0d",
               out_data.command, out_data.value_ma);
        mismatches++;
      end else begin
        e = expected_cmds.pop_front();
        if (out_data.command !== e.command) begin
          $error("command: expected %0d, got %0d", e.command, out_data.command);
          mismatches++;
        end
        if (out_data.value_ma !== e.value_ma) begin
          $error("value_ma: expected %0d, got %0d", e.value_ma, out_data.value_ma);
          mismatches++;
        end
        if (out_data.off_delay_50ms !== e.off_delay_50ms) begin
          $error("off_delay_50ms: expected %0d, got %0d", e.off_delay_50ms,
                 out_data.off_delay_50ms);
          mismatches++;
        end
        if (out_data.watchdog_kick !== e.watchdog_kick) begin
          $error("watchdog_kick: expected %0d, got %0d", e.watchdog_kick,
                 out_data.watchdog_kick);
          mismatches++;
        end
      end
    end
    if (rst_n && in_valid && !in_stall) expected_cmds.push_back(select_command(in_data));
  end

  // Result side: a requested long hold-off, otherwise random stall bursts while idle_on.
  always begin
    @(negedge clk);
    if (hold_len != 0) begin
      out_stall = 1'b1;
      repeat (hold_len) @(negedge clk);
      hold_len  = 0;
      out_stall = 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_stall = 1'b1;
      repeat ($urandom_range(1, 7)) @(negedge clk);
      out_stall = 1'b0;
    end
  end

  // Offer one word; return at the falling edge after it is taken, valid still high.
  task automatic send_word(input in_word_t w);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = w;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic tick(run_t run, int unsigned erpm, logic [31:0] t, logic rv, int rma,
                      logic [7:0] load);
    in_word_t w;
    w.run_state     = run;
    w.erpm_mag      = 18'(erpm);
    w.time_ms       = t;
    w.request_valid = rv;
    w.request_ma    = 20'(rma);
    w.click_load    = load;
    send_word(w);
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (expected_cmds.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk);
    case (idx)
      REG_BRAKE_CURRENT: brake_ma      = val[18:0];
      REG_CLICK_CURRENT: click_ma      = val[16:0];
      REG_PARKING_MODE:  park_mode     = park_t'(val[1:0]);
      REG_MOVING_THRESH: moving_thresh = val[17:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_config(logic [18:0] b, logic [16:0] c, park_t m, logic [17:0] th);
    wait_drained();
    write_reg(REG_BRAKE_CURRENT, b);
    write_reg(REG_CLICK_CURRENT, 19'(c));
    write_reg(REG_PARKING_MODE, 19'(m));
    write_reg(REG_MOVING_THRESH, 19'(th));
  endtask

  // Mostly monotonic time with random motion, requests and click loads; rare jumps as noise.
  function automatic in_word_t random_tick(int unsigned req_pct, int unsigned dis_pct);
    in_word_t    w;
    int unsigned r;
    int          th;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: now_ms = now_ms + $urandom_range(0, 300);
      6, 7:             now_ms = now_ms + $urandom_range(300, 1500);
      8:                ;
      default:          if ($urandom_range(0, 9) == 0) now_ms = $urandom;
    endcase
    w.time_ms = now_ms;

    r = $urandom_range(0, 99);
    if (r < dis_pct)  w.run_state = RUN_DISABLED;
    else if (r < 55)  w.run_state = RUN_RUNNING;
    else if (r < 90)  w.run_state = RUN_OTHER;
    else              w.run_state = RUN_OTHER_HI;

    th = int'(moving_thresh);
    case ($urandom_range(0, 5))
      0:       w.erpm_mag = 18'($urandom_range(0, 60));
      1:       w.erpm_mag = 18'($urandom_range(0, 2100));
      2:       w.erpm_mag = 18'((th < 20) ? $urandom_range(0, 40) :
                                (th > 262123) ? $urandom_range(262103, 262143) :
                                $urandom_range(th - 20, th + 20));
      3:       w.erpm_mag = 18'($urandom_range(0, 200000));
      4:       w.erpm_mag = 18'($urandom);
      default: w.erpm_mag = '0;
    endcase

    w.request_valid = ($urandom_range(0, 99) < req_pct);
    case ($urandom_range(0, 3))
      0, 1: w.request_ma = 20'(int'($urandom_range(0, 600000)) - 300000);
      2:    w.request_ma = 20'($urandom);
      default: begin
        case ($urandom_range(0, 4))
          0:       w.request_ma = 20'(-524288);
          1:       w.request_ma = 20'(524287);
          2:       w.request_ma = 20'(-400001);
          3:       w.request_ma = 20'(400001);
          default: w.request_ma = '0;
        endcase
      end
    endcase

    r = $urandom_range(0, 99);
    if (r < 4)       w.click_load = 8'($urandom_range(1, 12));
    else if (r == 4) w.click_load = 8'($urandom_range(1, 255));
    else             w.click_load = '0;
    return w;
  endfunction

  task automatic run_ticks(int n, int unsigned req_pct, int unsigned dis_pct);
    repeat (n) send_word(random_tick(req_pct, dis_pct));
  endtask

  // Disable handling, click pulses, saturation, parking modes, release and deadline overflow.
  task automatic test_edge_ticks();
    set_config(19'h7FFFF, 17'h1FFFF, PARK_IDLE, 18'd1000);
    tick(RUN_DISABLED, 0, 32'd0, 1'b1, -524288, 8'd3);
    tick(RUN_DISABLED, 0, 32'd10, 1'b0, 0, 8'd0);
    tick(RUN_RUNNING, 0, 32'd100, 1'b0, 0, 8'd0);
    tick(RUN_RUNNING, 0, 32'd110, 1'b0, 0, 8'd0);
    tick(RUN_OTHER, 10, 32'd120, 1'b0, 0, 8'd0);
    tick(RUN_OTHER, 5000, 32'd200, 1'b0, 0, 8'd0);
    tick(RUN_OTHER, 40, 32'd300, 1'b0, 0, 8'd0);
    tick(RUN_OTHER_HI, 1999, 32'd400, 1'b0, 0, 8'd0);
    tick(RUN_RUNNING, 100, 32'd500, 1'b0, 0, 8'd0);
    tick(RUN_OTHER, 0, 32'd1300, 1'b0, 0, 8'd0);
    tick(RUN_RUNNING, 0, 32'd1310, 1'b1, 524287, 8'd0);
    tick(RUN_RUNNING, 0, 32'd1320, 1'b1, 1, 8'd0);
    tick(RUN_RUNNING, 262143, 32'hFFFF_FC17, 1'b0, 0, 8'd0);
    tick(RUN_RUNNING, 262143, 32'hFFFF_FE00, 1'b0, 0, 8'd0);
    tick(RUN_OTHER, 0, 32'hFFFF_FFFF, 1'b0, 0, 8'd255);
    tick(RUN_DISABLED, 0, 32'hFFFF_FFFF, 1'b0, 0, 8'd0);
    wait_drained();
    write_reg(REG_PARKING_MODE, 19'(PARK_ALWAYS));
    tick(RUN_OTHER, 3000, 32'd5, 1'b0, 0, 8'd0);
    tick(RUN_OTHER, 10, 32'd6, 1'b0, 0, 8'd0);
    wait_drained();
    write_reg(REG_PARKING_MODE, 19'(PARK_HOLD));
    tick(RUN_OTHER, 10, 32'd7, 1'b0, 0, 8'd0);
    tick(RUN_RUNNING, 10, 32'd8, 1'b0, 0, 8'd0);
    tick(RUN_OTHER, 10, 32'd9, 1'b0, 0, 8'd0);
    wait_drained();
    write_reg(REG_PARKING_MODE, 19'(PARK_NEVER));
    tick(RUN_OTHER_HI, 10, 32'd10, 1'b0, -1, 8'd0);
    tick(RUN_OTHER, 10, 32'd1100, 1'b0, 0, 8'd0);
    wait_drained();
  endtask

  // Random ticks under a series of register settings, the extremes first.
  task automatic test_random_ticks();
    for (int p = 0; p < 6; p++) begin
      case (p)
        0:       set_config('0, '0, PARK_NEVER, '0);
        1:       set_config(19'h7FFFF, 17'h1FFFF, PARK_ALWAYS, 18'h3FFFF);
        2:       set_config(19'd20000, 17'd3000, PARK_IDLE, 18'd1000);
        3:       set_config(19'($urandom), 17'($urandom), PARK_HOLD, 18'($urandom));
        default: set_config(19'($urandom), 17'($urandom),
                            park_t'($urandom_range(0, 3)), 18'($urandom_range(0, 5000)));
      endcase
      now_ms = $urandom_range(0, 1) ? $urandom : 32'd0;
      run_ticks(150, 30, 8);
    end
    wait_drained();
  endtask

  // Hold the result side long enough for the block to back up into its input.
  task automatic test_backpressure();
    set_config(19'd15000, 17'd8000, PARK_IDLE, 18'd2500);
    hold_len = 80;
    run_ticks(60, 30, 5);
    wait_drained();
  endtask

  // Stop sending mid-stream until every result is back, then resume.
  task automatic test_sender_pause();
    run_ticks(30, 40, 10);
    in_valid = 1'b0;
    while (expected_cmds.size() != 0) @(negedge clk);
    run_ticks(30, 40, 10);
    wait_drained();
  endtask

  // Back-to-back words with no idling on either side.
  task automatic test_full_rate();
    set_config(19'd30000, 17'd12000, PARK_ALWAYS, 18'd800);
    idle_on = 1'b0;
    run_ticks(100, 30, 5);
    wait_drained();
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    out_stall      = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = REG_BRAKE_CURRENT;
    cfg_data       = '0;
    idle_on        = 1'b1;
    hold_len       = 0;
    now_ms         = '0;
    mismatches     = 0;
    brake_ma       = '0;
    click_ma       = '0;
    park_mode      = PARK_NEVER;
    moving_thresh  = 18'd1000;
    dis_seen       = 1'b0;
    park_on        = 1'b0;
    clicks_left    = '0;
    pend_req       = 1'b0;
    pend_ma        = 0;
    brake_deadline = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_edge_ticks();
    test_random_ticks();
    test_backpressure();
    test_sender_pause();
    test_full_rate();

    repeat (6) @(negedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
